>>> rtl/core/sabavg_pkg.sv
// Shared types, constants and tables for the two-sensor angular bin averager.
package sabavg_pkg;

    localparam int BIN_COUNT          = 1440;
    localparam int MAX_POINTS_PER_BIN = 1023;
    localparam int COORD_BITS         = 16;

    localparam int BIN_W    = $clog2(BIN_COUNT);
    localparam int CNT_W    = 10;
    localparam int SUM_W    = 26;
    localparam int RBIN_W   = 11;
    localparam int OFS_W    = 16;
    localparam int AVG_W    = 16;
    localparam int VEC_W    = COORD_BITS + 2;
    localparam int PROD_W   = 2 * VEC_W;
    localparam int SQ_W     = 2 * VEC_W - 2;
    localparam int CORD_W   = VEC_W + 23;
    localparam int ZACC_W   = 34;
    localparam int STEPS    = 30;
    localparam int STEP_W   = 5;
    localparam int ROT_Q15  = 23170;
    localparam int NUM_W    = SUM_W + 1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_POINT_A = 2'd0,
        ACT_POINT_B = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_OFFSET_X = 2'd0,
        CFG_OFFSET_Y = 2'd1,
        CFG_RSVD_2   = 2'd2,
        CFG_RSVD_3   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]                   action;
        logic signed [COORD_BITS-1:0] point_x_mm;
        logic signed [COORD_BITS-1:0] point_y_mm;
        logic [RBIN_W-1:0]            read_bin;
    } in_item_t;

    typedef struct packed {
        logic [RBIN_W-1:0] bin_number;
        logic [AVG_W-1:0]  average_range_mm;
        logic              bin_empty;
    } out_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } bin_entry_t;

    typedef enum logic [1:0] {
        CD_IDLE,
        CD_ITER,
        CD_BIN
    } cordic_state_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROT_A,
        ST_ROT_B,
        ST_XY,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SUM,
        ST_GO,
        ST_WAIT,
        ST_PT_RD,
        ST_PT_WR,
        ST_RD_RD,
        ST_RD_CHK,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/sabavg_cordic.sv
// Iterative CORDIC vectoring unit returning the angular bin of a point.
module sabavg_cordic (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [sabavg_pkg::VEC_W-1:0]  x_in,
    input  logic signed [sabavg_pkg::VEC_W-1:0]  y_in,
    output logic [sabavg_pkg::BIN_W-1:0]         bin,
    output logic                                 done
);
    import sabavg_pkg::*;

    localparam int BPROD_W = 32 + BIN_W + 2;

    cordic_state_t             state_reg, state_next;
    logic signed [CORD_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [ZACC_W-1:0]  z_reg, z_next;
    logic [1:0]                q_reg, q_next;
    logic [STEP_W-1:0]         i_reg, i_next;
    logic [BIN_W-1:0]          bin_reg, bin_next;
    logic                      done_reg, done_next;

    logic signed [VEC_W-1:0]   fx, fy;
    logic [1:0]                fq;
    logic signed [CORD_W-1:0]  dx, dy;
    logic signed [ZACC_W-1:0]  at;
    logic [29:0]               zc;
    logic [31:0]               ang;
    logic [BPROD_W-1:0]        bprod;
    logic [BPROD_W-33:0]       bsel;

    always_comb begin
        fx = x_in;
        fy = y_in;
        fq = 2'd0;
        if (x_in == '0 && y_in == '0) begin
            fq = 2'd0;
        end else if (x_in > 0 && y_in >= 0) begin
            fq = 2'd0;
        end else if (x_in <= 0 && y_in > 0) begin
            fx = y_in;
            fy = -x_in;
            fq = 2'd1;
        end else if (x_in < 0 && y_in <= 0) begin
            fx = -x_in;
            fy = -y_in;
            fq = 2'd2;
        end else begin
            fx = -y_in;
            fy = x_in;
            fq = 2'd3;
        end
    end

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign at = ZACC_W'(atan_turn(i_reg));

    always_comb begin
        if (z_reg < 0) begin
            zc = '0;
        end else if (z_reg > ZACC_W'(32'h3FFF_FFFF)) begin
            zc = '1;
        end else begin
            zc = z_reg[29:0];
        end
        ang   = {q_reg, zc};
        bprod = BPROD_W'(ang) * BPROD_W'(BIN_COUNT);
        bsel  = bprod[BPROD_W-1:32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        q_reg   <= q_next;
        i_reg   <= i_next;
        bin_reg <= bin_next;
    end

    always_comb begin
        state_next = state_reg;
        done_next  = done_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        q_next     = q_reg;
        i_next     = i_reg;
        bin_next   = bin_reg;
        unique case (state_reg)
            CD_IDLE: begin
                if (start) begin
                    done_next  = 1'b0;
                    x_next     = {{(CORD_W-VEC_W-20){fx[VEC_W-1]}}, fx, 20'd0};
                    y_next     = {{(CORD_W-VEC_W-20){fy[VEC_W-1]}}, fy, 20'd0};
                    z_next     = '0;
                    q_next     = fq;
                    i_next     = '0;
                    state_next = (fy == '0) ? CD_BIN : CD_ITER;
                end
            end
            CD_ITER: begin
                if (y_reg >= 0) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end
                i_next = i_reg + 1'b1;
                if (i_reg == STEP_W'(STEPS - 1)) begin
                    state_next = CD_BIN;
                end
            end
            CD_BIN: begin
                bin_next   = (bsel >= (BPROD_W-32)'(BIN_COUNT)) ? '0 : bsel[BIN_W-1:0];
                done_next  = 1'b1;
                state_next = CD_IDLE;
            end
            default: state_next = CD_IDLE;
        endcase
    end

    assign bin  = bin_reg;
    assign done = done_reg;

endmodule

>>> rtl/core/sabavg_isqrt.sv
// Bit-pair iterative integer square root, rounded and saturated to 16 bits.
module sabavg_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sabavg_pkg::SQ_W-1:0]   sq,
    output logic [sabavg_pkg::AVG_W-1:0]  root,
    output logic                          done
);
    import sabavg_pkg::*;

    localparam int W = SQ_W + 1;

    logic [W-1:0]     s_reg, r_reg, bit_reg;
    logic             busy_reg, done_reg;
    logic [AVG_W-1:0] root_reg;
    logic [W-1:0]     trial, rr;

    assign trial = r_reg + bit_reg;
    assign rr    = r_reg + W'(s_reg > r_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg && bit_reg == '0) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        if (start) begin
            s_reg   <= W'(sq);
            r_reg   <= '0;
            bit_reg <= W'(1) << (SQ_W - 2);
        end else if (busy_reg) begin
            if (bit_reg != '0) begin
                if (s_reg >= trial) begin
                    s_reg <= s_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end else begin
                root_reg <= (rr > W'(16'hFFFF)) ? '1 : rr[AVG_W-1:0];
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

>>> rtl/core/sabavg_div.sv
// Restoring divider, one quotient bit per cycle, for the bin average.
module sabavg_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sabavg_pkg::NUM_W-1:0]  num,
    input  logic [sabavg_pkg::CNT_W-1:0]  den,
    output logic [sabavg_pkg::AVG_W-1:0]  quo,
    output logic                          done
);
    import sabavg_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] n_reg;
    logic [CNT_W-1:0] d_reg, rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;
    logic [CNT_W:0]   rem_sh;
    logic             qbit;

    assign rem_sh = {rem_reg, n_reg[NUM_W-1]};
    assign qbit   = rem_sh >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg && cnt_reg == CW'(NUM_W - 1)) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        if (start) begin
            n_reg   <= num;
            d_reg   <= den;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= qbit ? CNT_W'(rem_sh - {1'b0, d_reg}) : rem_sh[CNT_W-1:0];
            n_reg   <= {n_reg[NUM_W-2:0], qbit};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign quo  = n_reg[AVG_W-1:0];
    assign done = done_reg;

endmodule

>>> rtl/core/two_sensor_angular_bin_averager.sv
// Top level: sequencer, shared multiplier, bin memory and result register.
//
//   channel  direction  handshake               payload
//   s_       in         s_valid / s_ready       s_data  (in_item_t)
//   m_       out        m_valid / m_ready       m_data  (out_item_t)
//   cfg_     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A point holds the block from its transfer to the next possible one: six multiply/add
// steps, a start step, the CORDIC (30 iterations, none if the folded y is zero, bin
// step, done; the square root ends earlier), a bin read and a write below 1023 points.
// A read past the last bin skips the bin memory; an empty bin skips the divider.
// A result held by m_ready low keeps the next read in its output step, s_ready low.
// After reset a clearing pass zeroes all 1440 bins of the bin memory; s_ready is low.
module two_sensor_angular_bin_averager (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sabavg_pkg::in_item_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sabavg_pkg::out_item_t  m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data
);
    import sabavg_pkg::*;

    state_t                   state_reg, state_next;
    in_item_t                 item_reg;
    logic signed [OFS_W-1:0]  ox_reg, oy_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [VEC_W-1:0]  rx_reg, rx_next, x_reg, x_next, y_reg, y_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic [BIN_W-1:0]         clr_reg;
    logic [AVG_W-1:0]         avg_reg, avg_next;
    logic                     empty_reg, empty_next;
    out_item_t                out_reg;
    logic                     m_valid_reg;
    logic                     out_load;

    bin_entry_t               mem [BIN_COUNT];
    bin_entry_t               rdata_reg;
    logic                     mem_rd, mem_we;
    logic [BIN_W-1:0]         mem_addr;
    bin_entry_t               mem_wdata;

    logic signed [VEC_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p, rnd;
    logic signed [VEC_W-1:0]  ry, xs, ys;
    logic [SUM_W:0]           sum_add;

    logic                     unit_go, div_go;
    logic [BIN_W-1:0]         cd_bin;
    logic                     cd_done, sq_done, dv_done;
    logic [AVG_W-1:0]         root, quo;

    sabavg_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(unit_go),
        .x_in(x_reg), .y_in(y_reg), .bin(cd_bin), .done(cd_done)
    );

    sabavg_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(unit_go),
        .sq(sq_reg), .root(root), .done(sq_done)
    );

    sabavg_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_go),
        .num(NUM_W'(rdata_reg.sum) + NUM_W'(rdata_reg.count >> 1)),
        .den(rdata_reg.count), .quo(quo), .done(dv_done)
    );

    assign mul_p   = mul_a * mul_b;
    assign rnd     = prod_reg + PROD_W'(16384);
    assign ry      = rnd[VEC_W+14:15];
    assign xs      = rx_reg + VEC_W'(ox_reg);
    assign ys      = ry + VEC_W'(oy_reg);
    assign sum_add = {1'b0, rdata_reg.sum} + (SUM_W+1)'(root);

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (mem_rd) begin
            rdata_reg <= mem[mem_addr];
        end
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            ox_reg      <= 16'sd352;
            oy_reg      <= 16'sd334;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_OFFSET_X: ox_reg <= cfg_data;
                    CFG_OFFSET_Y: oy_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (out_load) begin
            out_reg <= '{bin_number: item_reg.read_bin, average_range_mm: avg_reg,
                         bin_empty: empty_reg};
        end
        prod_reg  <= prod_next;
        rx_reg    <= rx_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        sq_reg    <= sq_next;
        avg_reg   <= avg_next;
        empty_reg <= empty_next;
    end

    always_comb begin
        state_next = state_reg;
        prod_next  = prod_reg;
        rx_next    = rx_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        sq_next    = sq_reg;
        avg_next   = avg_reg;
        empty_next = empty_reg;
        mul_a      = x_reg;
        mul_b      = x_reg;
        mem_rd     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = cd_bin;
        mem_wdata  = '0;
        unit_go    = 1'b0;
        div_go     = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                if (clr_reg == BIN_W'(BIN_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.action)
                        ACT_POINT_A, ACT_POINT_B: state_next = ST_ROT_A;
                        ACT_READ:                 state_next = ST_RD_RD;
                        default:                  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ROT_A: begin
                mul_a      = VEC_W'(item_reg.point_x_mm) + VEC_W'(item_reg.point_y_mm);
                mul_b      = VEC_W'(ROT_Q15);
                prod_next  = mul_p;
                state_next = ST_ROT_B;
            end
            ST_ROT_B: begin
                rx_next    = rnd[VEC_W+14:15];
                mul_a      = VEC_W'(item_reg.point_y_mm) - VEC_W'(item_reg.point_x_mm);
                mul_b      = VEC_W'(ROT_Q15);
                prod_next  = mul_p;
                state_next = ST_XY;
            end
            ST_XY: begin
                if (item_reg.action == ACT_POINT_B) begin
                    x_next = -xs;
                    y_next = -ys;
                end else begin
                    x_next = xs;
                    y_next = ys;
                end
                state_next = ST_SQ_X;
            end
            ST_SQ_X: begin
                mul_a      = x_reg;
                mul_b      = x_reg;
                prod_next  = mul_p;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                sq_next    = prod_reg[SQ_W-1:0];
                mul_a      = y_reg;
                mul_b      = y_reg;
                prod_next  = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                sq_next    = sq_reg + prod_reg[SQ_W-1:0];
                state_next = ST_GO;
            end
            ST_GO: begin
                unit_go    = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (cd_done && sq_done) begin
                    state_next = ST_PT_RD;
                end
            end
            ST_PT_RD: begin
                mem_rd     = 1'b1;
                state_next = ST_PT_WR;
            end
            ST_PT_WR: begin
                if (rdata_reg.count < CNT_W'(MAX_POINTS_PER_BIN)) begin
                    mem_we          = 1'b1;
                    mem_wdata.count = rdata_reg.count + 1'b1;
                    mem_wdata.sum   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                end
                state_next = ST_IDLE;
            end
            ST_RD_RD: begin
                mem_addr   = item_reg.read_bin[BIN_W-1:0];
                avg_next   = '0;
                empty_next = 1'b1;
                if (item_reg.read_bin >= RBIN_W'(BIN_COUNT)) begin
                    state_next = ST_OUT;
                end else begin
                    mem_rd     = 1'b1;
                    state_next = ST_RD_CHK;
                end
            end
            ST_RD_CHK: begin
                mem_addr = item_reg.read_bin[BIN_W-1:0];
                mem_we   = 1'b1;
                if (rdata_reg.count == '0) begin
                    state_next = ST_OUT;
                end else begin
                    div_go     = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (dv_done) begin
                    avg_next   = quo;
                    empty_next = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("input taken during clearing pass");
    a_read_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.action == ACT_READ) |=> !s_ready)
        else $error("read transfer did not start work");
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (mem_addr < BIN_W'(BIN_COUNT)))
        else $error("bin memory write out of range");
    a_load_keeps_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !out_load)
        else $error("pending result overwritten");
`endif

endmodule
